// ===== src/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Widths, reset values, register indexes and controller/datapath interface
// types for the Mandelbrot escape-time core.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// coordinate format: signed fixed point, FRAC_W fraction bits
	localparam int COORD_W    = 32;
	localparam int FRAC_W     = 28;
	localparam int ITER_W     = 16;
	localparam int PIX_W      = 12;

	// register field widths
	localparam int SIZE_W     = 13;
	localparam int LIMIT_W    = 32;
	localparam int MAXIT_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// derived datapath widths
	localparam int MAG_W      = COORD_W + 1;          // |end - start|
	localparam int DIV_W      = MAG_W + PIX_W;        // |diff| * pixel
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int SUM_W      = DIV_W + 2;            // start +/- quotient
	localparam int PROD_W     = 2 * COORD_W;          // full-width square
	localparam int TERM_W     = PROD_W + 2;           // new z before shift
	localparam int CMP_W      = (ITER_W > MAXIT_W) ? ITER_W : MAXIT_W;

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// reset values: window -2.0..1.0 by -1.5..1.5, 640x480, limit 4.0, cap 256
	localparam logic [COORD_W-1:0] X_START_RST = COORD_W'(-(longint'(2) <<< FRAC_W));
	localparam logic [COORD_W-1:0] X_END_RST   = COORD_W'(longint'(1) <<< FRAC_W);
	localparam logic [COORD_W-1:0] Y_START_RST = COORD_W'(-(longint'(3) <<< (FRAC_W - 1)));
	localparam logic [COORD_W-1:0] Y_END_RST   = COORD_W'(longint'(3) <<< (FRAC_W - 1));
	localparam logic [SIZE_W-1:0]  WIDTH_RST   = SIZE_W'(640);
	localparam logic [SIZE_W-1:0]  HEIGHT_RST  = SIZE_W'(480);
	localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(longint'(4) <<< FRAC_W);
	localparam logic [MAXIT_W-1:0] MAXIT_RST   = MAXIT_W'(256);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_START    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_X_END      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_Y_START    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Y_END      = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = CFG_IDX_W'(7);

	typedef enum logic {
		AXIS_X,
		AXIS_Y
	} axis_t;

	typedef struct packed {
		logic  load;        // capture pixel, clear z and count
		axis_t axis;        // which coordinate the mapping works on
		logic  map_mul;     // register |diff| * pixel
		logic  div_start;   // launch the divider
		logic  map_store;   // write mapped c for axis
		logic  iter_mul;    // register squares and cross product
		logic  iter_step;   // update z, bump count
		logic  out_load;    // move result into output registers
	} mbe_cmd_t;

	typedef struct packed {
		logic div_done;
		logic iter_stop;
	} mbe_status_t;

endpackage

// ===== src/mbe_div.sv =====
// ----------------------------------------------------------------------------
// mbe_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbe_div import mbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [SIZE_W:0]      rem_shift;
	logic [SIZE_W:0]      rem_sub;
	logic                 ge;

	// dividend bits shift out of the top of quo_q as quotient bits enter below
	assign rem_shift = {rem_q, quo_q[DIV_W-1]};
	assign ge        = rem_shift >= {1'b0, divisor};
	assign rem_sub   = rem_shift - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[SIZE_W-1:0] : rem_shift[SIZE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/mbe_datapath.sv =====
// ----------------------------------------------------------------------------
// mbe_datapath
// Configuration registers, pixel-to-plane mapping and the z = z^2 + c
// iteration unit, driven by the controller's commands.
// ----------------------------------------------------------------------------
module mbe_datapath import mbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PIX_W-1:0]      column,
	input  logic [PIX_W-1:0]      row,
	input  mbe_cmd_t              cmd,
	output mbe_status_t           status,
	output logic [ITER_W-1:0]     iteration_count,
	output logic [PIX_W-1:0]      out_column,
	output logic [PIX_W-1:0]      out_row
);

	// configuration
	logic [COORD_W-1:0] x_start_q, x_end_q, y_start_q, y_end_q;
	logic [SIZE_W-1:0]  width_q, height_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [MAXIT_W-1:0] max_iter_q;

	// pixel and working state
	logic [PIX_W-1:0]   col_q, row_q;
	logic [COORD_W-1:0] c_re_q, c_im_q, z_re_q, z_im_q;
	logic [ITER_W-1:0]  count_q;

	// mapping
	logic [COORD_W-1:0]      start_sel, end_sel;
	logic [PIX_W-1:0]        pix_sel;
	logic [SIZE_W-1:0]       size_sel;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        diff_mag;
	logic [DIV_W-1:0]        prod_q;
	logic                    neg_q, zero_q;
	logic                    div_done;
	logic [DIV_W-1:0]        quot;
	logic signed [SUM_W-1:0] q_signed, map_sum;
	logic [COORD_W-1:0]      c_new;

	// iteration
	logic [COORD_W-1:0]       ax, ay;
	logic [PROD_W-1:0]        xx_q, yy_q, xy_q;
	logic                     xy_neg_q;
	logic [PROD_W:0]          sq_sum, limit_wide;
	logic                     cap_hit, escaped;
	logic signed [TERM_W-1:0] xy2, t_sum, u_sum, t_sh, u_sh, c_re_w, c_im_w;
	logic [COORD_W-1:0]       z_re_new, z_im_new;

	// output registers
	logic [ITER_W-1:0] count_out_q;
	logic [PIX_W-1:0]  col_out_q, row_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q  <= X_START_RST;
			x_end_q    <= X_END_RST;
			y_start_q  <= Y_START_RST;
			y_end_q    <= Y_END_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			limit_q    <= LIMIT_RST;
			max_iter_q <= MAXIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_START:   x_start_q  <= cfg_data[COORD_W-1:0];
				REG_X_END:     x_end_q    <= cfg_data[COORD_W-1:0];
				REG_Y_START:   y_start_q  <= cfg_data[COORD_W-1:0];
				REG_Y_END:     y_end_q    <= cfg_data[COORD_W-1:0];
				REG_WIDTH:     width_q    <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:    height_q   <= cfg_data[SIZE_W-1:0];
				REG_ESC_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_MAX_ITER:  max_iter_q <= cfg_data[MAXIT_W-1:0];
			endcase
		end
	end

	// ---- mapping: c = start + trunc((end - start) * p / size) ----
	always_comb begin
		if (cmd.axis == AXIS_X) begin
			start_sel = x_start_q;
			end_sel   = x_end_q;
			pix_sel   = col_q;
			size_sel  = width_q;
		end else begin
			start_sel = y_start_q;
			end_sel   = y_end_q;
			pix_sel   = row_q;
			size_sel  = height_q;
		end
	end

	assign diff     = $signed({end_sel[COORD_W-1], end_sel})
	                - $signed({start_sel[COORD_W-1], start_sel});
	assign diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

	always_ff @(posedge clk) begin
		if (cmd.map_mul) begin
			prod_q <= diff_mag * pix_sel;
			neg_q  <= diff[MAG_W-1];
			zero_q <= (size_sel == '0);
		end
	end

	mbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (size_sel),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		// zero size maps every pixel onto start
		if (zero_q)
			q_signed = '0;
		else if (neg_q)
			q_signed = -$signed({2'b00, quot});
		else
			q_signed = $signed({2'b00, quot});
		map_sum = $signed({{(SUM_W-COORD_W){start_sel[COORD_W-1]}}, start_sel}) + q_signed;
		if (&map_sum[SUM_W-1:COORD_W-1] || ~|map_sum[SUM_W-1:COORD_W-1])
			c_new = map_sum[COORD_W-1:0];
		else
			c_new = map_sum[SUM_W-1] ? COORD_MIN : COORD_MAX;
	end

	always_ff @(posedge clk) begin
		if (cmd.map_store) begin
			if (cmd.axis == AXIS_X)
				c_re_q <= c_new;
			else
				c_im_q <= c_new;
		end
	end

	// ---- iteration ----
	assign ax = z_re_q[COORD_W-1] ? COORD_W'(-z_re_q) : z_re_q;
	assign ay = z_im_q[COORD_W-1] ? COORD_W'(-z_im_q) : z_im_q;

	always_ff @(posedge clk) begin
		if (cmd.iter_mul) begin
			xx_q     <= ax * ax;
			yy_q     <= ay * ay;
			xy_q     <= ax * ay;
			xy_neg_q <= z_re_q[COORD_W-1] ^ z_im_q[COORD_W-1];
		end
	end

	assign sq_sum     = {1'b0, xx_q} + {1'b0, yy_q};
	assign limit_wide = (PROD_W + 1)'(limit_q) << FRAC_W;
	assign escaped    = sq_sum > limit_wide;
	assign cap_hit    = (CMP_W'(count_q) >= CMP_W'(max_iter_q)) || (&count_q);

	assign status.iter_stop = cap_hit || escaped;
	assign status.div_done  = div_done;

	always_comb begin
		c_re_w = $signed({{(TERM_W-COORD_W){c_re_q[COORD_W-1]}}, c_re_q}) <<< FRAC_W;
		c_im_w = $signed({{(TERM_W-COORD_W){c_im_q[COORD_W-1]}}, c_im_q}) <<< FRAC_W;
		xy2    = $signed({1'b0, xy_q, 1'b0});
		t_sum  = $signed({2'b00, xx_q}) - $signed({2'b00, yy_q}) + c_re_w;
		u_sum  = (xy_neg_q ? -xy2 : xy2) + c_im_w;
		t_sh   = t_sum >>> FRAC_W;
		u_sh   = u_sum >>> FRAC_W;
		if (&t_sh[TERM_W-1:COORD_W-1] || ~|t_sh[TERM_W-1:COORD_W-1])
			z_re_new = t_sh[COORD_W-1:0];
		else
			z_re_new = t_sh[TERM_W-1] ? COORD_MIN : COORD_MAX;
		if (&u_sh[TERM_W-1:COORD_W-1] || ~|u_sh[TERM_W-1:COORD_W-1])
			z_im_new = u_sh[COORD_W-1:0];
		else
			z_im_new = u_sh[TERM_W-1] ? COORD_MIN : COORD_MAX;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q   <= column;
			row_q   <= row;
			z_re_q  <= '0;
			z_im_q  <= '0;
			count_q <= '0;
		end else if (cmd.iter_step) begin
			z_re_q  <= z_re_new;
			z_im_q  <= z_im_new;
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			count_out_q <= count_q;
			col_out_q   <= col_q;
			row_out_q   <= row_q;
		end
	end

	assign iteration_count = count_out_q;
	assign out_column      = col_out_q;
	assign out_row         = row_out_q;

endmodule

// ===== src/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: maps both axes through the shared divider, runs the iteration
// loop and hands the count to the output register.
// ----------------------------------------------------------------------------
module mbe_ctrl import mbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  mbe_status_t status,
	output mbe_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_MAP_MUL  = 3'd1;
	localparam logic [2:0] S_DIV_GO   = 3'd2;
	localparam logic [2:0] S_MAP_WAIT = 3'd3;
	localparam logic [2:0] S_ITER_MUL = 3'd4;
	localparam logic [2:0] S_ITER_CHK = 3'd5;
	localparam logic [2:0] S_FINISH   = 3'd6;

	logic [2:0] state_q, state_d;
	axis_t      axis_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MAP_MUL;
				end
			end
			S_MAP_MUL: begin
				cmd.map_mul = 1'b1;
				state_d     = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_MAP_WAIT;
			end
			S_MAP_WAIT: begin
				if (status.div_done) begin
					cmd.map_store = 1'b1;
					state_d       = (axis_q == AXIS_Y) ? S_ITER_MUL : S_MAP_MUL;
				end
			end
			S_ITER_MUL: begin
				cmd.iter_mul = 1'b1;
				state_d      = S_ITER_CHK;
			end
			S_ITER_CHK: begin
				if (status.iter_stop) begin
					state_d = S_FINISH;
				end else begin
					cmd.iter_step = 1'b1;
					state_d       = S_ITER_MUL;
				end
			end
			S_FINISH: begin
				// wait here only while the previous result is still unclaimed
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				axis_q <= AXIS_X;
			else if (cmd.map_store)
				axis_q <= AXIS_Y;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time pixel engine: maps (column, row) onto the configured window and
// counts z = z^2 + c iterations until escape or the iteration cap.
//
//   channel  | handshake             | beat contents
//   ---------+-----------------------+-------------------------------------
//   in       | in_valid / in_ready   | column, row
//   out      | out_valid / out_ready | iteration_count, out_column, out_row
//   cfg      | cfg_we                | cfg_index, cfg_data (write only)
//
// For each pixel the core runs two divisions (one per axis, 45 quotient bits
// each) on the shared divider, then a multiply/update loop per iteration
// plus a final check.
// One pixel is in work at a time; the next beat is taken while a finished
// result still waits in the output register.
// A stalled output holds the engine only at the end of the following pixel.
// Reset is asynchronous; it restores the default window and empties the core.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core import mbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      column,
	input  logic [PIX_W-1:0]      row,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ITER_W-1:0]     iteration_count,
	output logic [PIX_W-1:0]      out_column,
	output logic [PIX_W-1:0]      out_row,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mbe_cmd_t    cmd;
	mbe_status_t status;

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mbe_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.column          (column),
		.row             (row),
		.cmd             (cmd),
		.status          (status),
		.iteration_count (iteration_count),
		.out_column      (out_column),
		.out_row         (out_row)
	);

endmodule

// ===== src/mbe_checker.sv =====
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the escape-time core, attached by bind.
// ----------------------------------------------------------------------------
module mbe_checker import mbe_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [PIX_W-1:0]      column,
	input logic [PIX_W-1:0]      row,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [ITER_W-1:0]     iteration_count,
	input logic [PIX_W-1:0]      out_column,
	input logic [PIX_W-1:0]      out_row,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic [1:0] pending_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else
			pending_q <= pending_q + {1'b0, in_beat} - {1'b0, out_beat};
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("core ready again right after taking a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(iteration_count)
			&& $stable(out_column) && $stable(out_row))
		else $error("stalled result changed or dropped");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result with no beat outstanding");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> pending_q != 2'd2 && pending_q != 2'd3)
		else $error("ready with two beats already held");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while core was idle");

	logic unused_ok;
	assign unused_ok = ^{column, row, cfg_we, cfg_index, cfg_data};

endmodule

bind mandelbrot_escape_time_core mbe_checker u_mbe_checker (.*);
